@@ rtl/core/gn3_pkg.sv @@
// shared types and constants for the 3d gradient noise evaluator
`timescale 1ns / 1ps

package gn3_pkg;

   localparam logic OpStore = 1'b0;
   localparam logic OpEval  = 1'b1;

   // widest coordinate and fraction that any legal build needs
   localparam int MaxCoordBits = 6;
   localparam int MaxFracBits  = 24;
   localparam int GradBits     = 16;
   localparam int NoiseBits    = 16;

   localparam int QueueDepth = 4;
   localparam int QPtrBits   = 2;

   // one classified item as it waits between front and back
   typedef struct packed {
      logic                                  is_store;
      logic                                  oor;
      logic [2:0][MaxCoordBits-1:0]          coord;
      logic [2:0][GradBits-1:0]              grad;
      logic [2:0][MaxFracBits-1:0]           frac;
   } gn3_item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } gn3_qstat_type;

endpackage

@@ rtl/core/gn3_front.sv @@
// front end: classifies an incoming item and splits the position into cell and fraction
`timescale 1ns / 1ps

module gn3_front #(
   parameter int GRID_SIZE = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                       req_operation,
   input  logic [3:0]                 req_cell_x,
   input  logic [3:0]                 req_cell_y,
   input  logic [3:0]                 req_cell_z,
   input  logic signed [15:0]         req_grad_x,
   input  logic signed [15:0]         req_grad_y,
   input  logic signed [15:0]         req_grad_z,
   input  logic [19:0]                req_pos_x,
   input  logic [19:0]                req_pos_y,
   input  logic [19:0]                req_pos_z,
   output gn3_pkg::gn3_item_type      item
);

   localparam int BW = (FRAC_BITS < 20) ? 20 - FRAC_BITS : 1;

   logic [2:0][19:0]  pos;
   logic [2:0][3:0]   cell_idx;
   logic [BW-1:0]     base [3];
   logic              base_oor;
   logic              cell_oor;

   always_comb begin
      pos      = {req_pos_z, req_pos_y, req_pos_x};
      cell_idx = {req_cell_z, req_cell_y, req_cell_x};
      base_oor = 1'b0;
      cell_oor = 1'b0;
      for (int a = 0; a < 3; a++) begin
         base[a] = BW'(pos[a] >> FRAC_BITS);
         // upper corner must stay inside the table
         if ((32'(base[a]) + 32'd1) >= 32'(GRID_SIZE)) begin
            base_oor = 1'b1;
         end
         if (32'(cell_idx[a]) >= 32'(GRID_SIZE)) begin
            cell_oor = 1'b1;
         end
      end

      item.is_store = (req_operation == gn3_pkg::OpStore);
      item.grad     = {req_grad_z, req_grad_y, req_grad_x};
      for (int a = 0; a < 3; a++) begin
         item.frac[a] = gn3_pkg::MaxFracBits'(pos[a]);
         if (item.is_store) begin
            item.coord[a] = gn3_pkg::MaxCoordBits'(cell_idx[a]);
         end else begin
            item.coord[a] = gn3_pkg::MaxCoordBits'(base[a]);
         end
      end
      // for a store this marks an ignored write
      item.oor = item.is_store ? cell_oor : base_oor;
   end

endmodule

@@ rtl/core/gn3_queue.sv @@
// short item queue between the front end and the evaluation pipeline
`timescale 1ns / 1ps

module gn3_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gn3_pkg::gn3_item_type      push_item,
   input  logic                       pop,
   output gn3_pkg::gn3_item_type      head_item,
   output gn3_pkg::gn3_qstat_type     stat
);

   gn3_pkg::gn3_item_type                entries_ff [gn3_pkg::QueueDepth];
   logic [gn3_pkg::QPtrBits-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [gn3_pkg::QPtrBits-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [gn3_pkg::QPtrBits:0]           count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = entries_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.full      = (count_ff == (gn3_pkg::QPtrBits + 1)'(gn3_pkg::QueueDepth));

endmodule

@@ rtl/core/gn3_back.sv @@
// back end: banked gradient table, dot products, smoothstep weights and trilinear blend
`timescale 1ns / 1ps

module gn3_back #(
   parameter int GRID_SIZE = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  gn3_pkg::gn3_item_type      in_item,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [15:0]                rsp_noise_value,
   output logic                       rsp_out_of_range
);

   localparam int F         = FRAC_BITS;
   localparam int IW        = $clog2(GRID_SIZE);
   localparam int HW        = (IW > 1) ? IW - 1 : 1;
   localparam int AW        = 3 * HW;
   localparam int BankDepth = 1 << AW;
   localparam int OW        = F + 2;
   localparam int PW        = OW + 16;
   localparam int DW        = F + 5;
   localparam int XW        = (F + 2) + (DW + 1);
   localparam int TW        = DW + F + 18;

   localparam logic signed [OW-1:0]   OneOff    = OW'(1) << F;
   localparam logic signed [PW+1:0]   DotHalf   = (PW + 2)'(8192);
   localparam logic signed [XW-1:0]   BlendHalf = XW'(1) << (F - 1);
   localparam logic signed [TW-1:0]   OneT      = TW'(1) << F;
   localparam logic [2*F:0]           SqHalf    = (2 * F + 1)'(1) << (F - 1);
   localparam logic [2*F+2:0]         WtHalf    = (2 * F + 3)'(1) << (F - 1);
   localparam logic [F+1:0]           ThreeOne  = (F + 2)'(3) << F;

   // half coordinate inside a parity bank, adj steps to the neighbor cell
   function automatic logic [HW-1:0] half_of(input logic [IW-1:0] c, input logic adj);
      logic [IW:0] s;
      s = {1'b0, c} + {{IW{1'b0}}, adj};
      return s[HW:1];
   endfunction

   function automatic logic signed [XW-1:0] blend_prod(input logic [F:0] s,
                                                       input logic signed [DW-1:0] a,
                                                       input logic signed [DW-1:0] b);
      logic signed [DW:0]  d;
      logic signed [F+1:0] ss;
      d  = b - a;
      ss = $signed({1'b0, s});
      return ss * d;
   endfunction

   function automatic logic signed [DW-1:0] blend_done(input logic signed [DW-1:0] a,
                                                       input logic signed [XW-1:0] p);
      logic signed [XW-1:0] t;
      t = (p + BlendHalf) >>> F;
      t = t + a;
      return t[DW-1:0];
   endfunction

   logic adv;
   logic out_v_ff;

   assign adv = !out_v_ff || rsp_ready;
   assign pop = adv && in_valid;

   // ---------------- issue: table write or eight bank reads
   logic [IW-1:0]  c [3];
   logic           wr_en;
   logic           rd_en;
   logic [2:0]     wr_bank;
   logic [AW-1:0]  wr_addr;
   logic [47:0]    wr_data;
   logic [47:0]    rd_ff [8];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         c[a] = in_item.coord[a][IW-1:0];
      end
      wr_en   = pop && in_item.is_store && !in_item.oor;
      rd_en   = pop && !in_item.is_store;
      wr_bank = {c[2][0], c[1][0], c[0][0]};
      wr_addr = {half_of(c[2], 1'b0), half_of(c[1], 1'b0), half_of(c[0], 1'b0)};
      wr_data = {in_item.grad[2], in_item.grad[1], in_item.grad[0]};
   end

   // each corner of a cell lands in a different parity bank
   for (genvar b = 0; b < 8; b++) begin : g_bank
      localparam logic [2:0] BankId = 3'(b);
      logic [47:0]   mem_ff [BankDepth];
      logic [AW-1:0] raddr;

      assign raddr = {half_of(c[2], BankId[2] ^ c[2][0]),
                      half_of(c[1], BankId[1] ^ c[1][0]),
                      half_of(c[0], BankId[0] ^ c[0][0])};

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == BankId)) begin
            mem_ff[wr_addr] <= wr_data;
         end
         if (rd_en && adv) begin
            rd_ff[b] <= mem_ff[raddr];
         end
      end
   end

   logic           v1_ff, oor1_ff;
   logic [2:0]     lsb1_ff;
   logic [F-1:0]   f1_ff [3];
   logic [2*F-1:0] ff1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= pop && !in_item.is_store;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oor1_ff <= in_item.oor;
         lsb1_ff <= {c[2][0], c[1][0], c[0][0]};
         for (int a = 0; a < 3; a++) begin
            f1_ff[a]  <= in_item.frac[a][F-1:0];
            ff1_ff[a] <= in_item.frac[a][F-1:0] * in_item.frac[a][F-1:0];
         end
      end
   end

   // ---------------- stage 2: corner products and weight product
   logic signed [PW-1:0] prod2_in [8][3];
   logic signed [PW-1:0] prod2_ff [8][3];
   logic [2*F+2:0]       wp2_in [3];
   logic [2*F+2:0]       wp2_ff [3];
   logic                 v2_ff, oor2_ff;

   always_comb begin
      logic [2:0]            src;
      logic signed [OW-1:0]  fs;
      logic signed [OW-1:0]  offv;
      logic [2*F:0]          ffr;
      logic [F:0]            f2;
      logic [F+1:0]          k;
      for (int i = 0; i < 8; i++) begin
         src = 3'(i) ^ lsb1_ff;
         for (int a = 0; a < 3; a++) begin
            fs   = $signed({2'b00, f1_ff[a]});
            offv = (((i >> a) & 1) != 0) ? fs - OneOff : fs;
            prod2_in[i][a] = $signed(rd_ff[src][16*a +: 16]) * offv;
         end
      end
      for (int a = 0; a < 3; a++) begin
         ffr       = {1'b0, ff1_ff[a]} + SqHalf;
         f2        = ffr[2*F:F];
         k         = ThreeOne - {1'b0, f1_ff[a], 1'b0};
         wp2_in[a] = f2 * k;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oor2_ff  <= oor1_ff;
         prod2_ff <= prod2_in;
         wp2_ff   <= wp2_in;
      end
   end

   // ---------------- stage 3: rounded dot products and weights
   logic signed [DW-1:0] dots3_in [8];
   logic signed [DW-1:0] dots3_ff [8];
   logic [F:0]           s3_in [3];
   logic [F:0]           s3_ff [3];
   logic                 v3_ff, oor3_ff;

   always_comb begin
      logic signed [PW+1:0] dsum;
      logic signed [PW+1:0] dsh;
      logic [2*F+2:0]       wr;
      for (int i = 0; i < 8; i++) begin
         dsum = prod2_ff[i][0];
         dsum = dsum + prod2_ff[i][1];
         dsum = dsum + prod2_ff[i][2];
         dsh  = (dsum + DotHalf) >>> 14;
         dots3_in[i] = $signed(dsh[DW-1:0]);
      end
      for (int a = 0; a < 3; a++) begin
         wr       = wp2_ff[a] + WtHalf;
         s3_in[a] = wr[2*F:F];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oor3_ff  <= oor2_ff;
         dots3_ff <= dots3_in;
         s3_ff    <= s3_in;
      end
   end

   // ---------------- stage 4: x blend products
   logic signed [XW-1:0] px4_ff [4];
   logic signed [DW-1:0] a4_ff [4];
   logic [F:0]           sy4_ff, sz4_ff;
   logic                 v4_ff, oor4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oor4_ff <= oor3_ff;
         sy4_ff  <= s3_ff[1];
         sz4_ff  <= s3_ff[2];
         for (int j = 0; j < 4; j++) begin
            a4_ff[j]  <= dots3_ff[2*j];
            px4_ff[j] <= blend_prod(s3_ff[0], dots3_ff[2*j], dots3_ff[2*j+1]);
         end
      end
   end

   // ---------------- stage 5: x blend done, y blend products
   logic signed [DW-1:0] xr [4];
   logic signed [XW-1:0] py5_ff [2];
   logic signed [DW-1:0] a5_ff [2];
   logic [F:0]           sz5_ff;
   logic                 v5_ff, oor5_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         xr[j] = blend_done(a4_ff[j], px4_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oor5_ff <= oor4_ff;
         sz5_ff  <= sz4_ff;
         for (int j = 0; j < 2; j++) begin
            a5_ff[j]  <= xr[2*j];
            py5_ff[j] <= blend_prod(sy4_ff, xr[2*j], xr[2*j+1]);
         end
      end
   end

   // ---------------- stage 6: y blend done, z blend product
   logic signed [DW-1:0] yr [2];
   logic signed [XW-1:0] pz6_ff;
   logic signed [DW-1:0] a6_ff;
   logic                 v6_ff, oor6_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         yr[j] = blend_done(a5_ff[j], py5_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oor6_ff <= oor5_ff;
         a6_ff   <= yr[0];
         pz6_ff  <= blend_prod(sz5_ff, yr[0], yr[1]);
      end
   end

   // ---------------- output: map to (r+1)/2, saturate, zero when out of range
   logic signed [DW-1:0] r;
   logic signed [TW-1:0] rt;
   logic signed [TW-1:0] vt;
   logic [15:0]          noise_in;
   logic [15:0]          noise_ff;
   logic                 oor_ff;

   always_comb begin
      r  = blend_done(a6_ff, pz6_ff);
      rt = r;
      vt = (((rt + OneT) <<< 16) + OneT) >>> (F + 1);
      if (vt < 0) begin
         noise_in = '0;
      end else if (vt > 65535) begin
         noise_in = 16'hFFFF;
      end else begin
         noise_in = vt[15:0];
      end
      if (oor6_ff) begin
         noise_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         noise_ff <= noise_in;
         oor_ff   <= oor6_ff;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_noise_value  = noise_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

@@ rtl/core/gradient_noise_3d_eval.sv @@
// top level of the 3d gradient noise evaluator
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   operation, cell xyz, grad xyz, pos xyz
//   rsp       out        rsp_valid/rsp_ready   noise_value, out_of_range
//
// one item per cycle sustained while rsp_ready holds; an evaluate item's result passes
// the issue stage, stages 2 to 6 and the output register after it leaves the queue
// a store gives no result and writes the table as it leaves the queue
// the table is eight parity banks, one read port each, so all corners are read at once
// a 4-entry queue parts front and back; req_ready drops only when that queue is full
// a stalled result freezes the whole back pipeline; reset clears control state only,
// the gradient table holds nothing valid until it is written
`timescale 1ns / 1ps

module gradient_noise_3d_eval #(
   parameter int GRID_SIZE = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [3:0]           req_cell_x,
   input  logic [3:0]           req_cell_y,
   input  logic [3:0]           req_cell_z,
   input  logic signed [15:0]   req_grad_x,
   input  logic signed [15:0]   req_grad_y,
   input  logic signed [15:0]   req_grad_z,
   input  logic [19:0]          req_pos_x,
   input  logic [19:0]          req_pos_y,
   input  logic [19:0]          req_pos_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_noise_value,
   output logic                 rsp_out_of_range
);

   gn3_pkg::gn3_item_type   front_item;
   gn3_pkg::gn3_item_type   head_item;
   gn3_pkg::gn3_qstat_type  q_stat;
   logic                    q_push;
   logic                    q_pop;

   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && req_ready;

   gn3_front #(
      .GRID_SIZE (GRID_SIZE),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_operation (req_operation),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_cell_z    (req_cell_z),
      .req_grad_x    (req_grad_x),
      .req_grad_y    (req_grad_y),
      .req_grad_z    (req_grad_z),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .item          (front_item)
   );

   gn3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   gn3_back #(
      .GRID_SIZE (GRID_SIZE),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (q_stat.not_empty),
      .in_item          (head_item),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_noise_value  (rsp_noise_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

   a_oor_gives_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_noise_value == '0)
      else $error("out of range result with nonzero noise");

   a_pop_only_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.not_empty)
      else $error("back end took an item from an empty queue");

   a_full_holds : assert property (@(posedge clock) disable iff (reset)
      q_stat.full && !q_pop |=> q_stat.full)
      else $error("queue lost an item while full");

endmodule

@@ verif/gradient_noise_3d_eval_tb.sv @@
// self-checking testbench for the 3d gradient noise evaluator
`timescale 1ns / 1ps

module gradient_noise_3d_eval_tb;

   localparam int Grid = 16;
   localparam int Frac = 16;
   localparam int Cells = Grid * Grid * Grid;
   localparam int TargetItems = 1100;
   localparam int CycleLimit = 400000;
   localparam int QuietTail = 150;
   localparam int LongHold = 300;

   typedef struct {
      logic              op;
      logic [3:0]        cx, cy, cz;
      logic [15:0]       gx, gy, gz;
      logic [19:0]       px, py, pz;
      bit                drain_first;
   } noise_req_type;

   typedef struct {
      logic [15:0] noise;
      logic        oor;
   } noise_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = 1'b0;
   logic [3:0] req_cell_x = '0, req_cell_y = '0, req_cell_z = '0;
   logic signed [15:0] req_grad_x = '0, req_grad_y = '0, req_grad_z = '0;
   logic [19:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_noise_value;
   logic rsp_out_of_range;

   gradient_noise_3d_eval #(.GRID_SIZE(Grid), .FRAC_BITS(Frac)) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   noise_req_type pending_items[$];
   noise_rsp_type expected_noise[$];
   logic [15:0] grad_mirror[Cells][3];
   bit written[Cells];
   int errors = 0;
   int items_made = 0;
   int items_sent = 0;
   int cycles = 0;
   bit quiet = 1'b0;

   function automatic longint round_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint smoothstep(longint f);
      longint f2;
      f2 = round_shift(f * f, Frac);
      return round_shift(f2 * (3 * (longint'(1) <<< Frac) - 2 * f), Frac);
   endfunction

   function automatic longint lerp(longint a, longint b, longint s);
      return a + round_shift(s * (b - a), Frac);
   endfunction

   // updates the mirror table or returns the expected noise result
   function automatic bit predict_noise(noise_req_type it, output noise_rsp_type res);
      longint one, f[3], w[3], d[8], sum, r, v;
      int base[3], idx, bx, by, bz;
      logic [19:0] p[3];
      one = longint'(1) <<< Frac;
      if (it.op == gn3_pkg::OpStore) begin
         idx = (int'(it.cx) * Grid + int'(it.cy)) * Grid + int'(it.cz);
         grad_mirror[idx][0] = it.gx;
         grad_mirror[idx][1] = it.gy;
         grad_mirror[idx][2] = it.gz;
         return 1'b0;
      end
      p[0] = it.px; p[1] = it.py; p[2] = it.pz;
      for (int i = 0; i < 3; i++) begin
         base[i] = int'(p[i] >> Frac);
         f[i] = longint'(p[i] & ((1 << Frac) - 1));
         if (base[i] + 1 >= Grid) begin
            res.noise = '0;
            res.oor = 1'b1;
            return 1'b1;
         end
         w[i] = smoothstep(f[i]);
      end
      for (int i = 0; i < 8; i++) begin
         bx = i & 1; by = (i >> 1) & 1; bz = (i >> 2) & 1;
         idx = ((base[0] + bx) * Grid + base[1] + by) * Grid + base[2] + bz;
         sum = longint'($signed(grad_mirror[idx][0])) * (bx ? f[0] - one : f[0])
             + longint'($signed(grad_mirror[idx][1])) * (by ? f[1] - one : f[1])
             + longint'($signed(grad_mirror[idx][2])) * (bz ? f[2] - one : f[2]);
         d[i] = round_shift(sum, 14);
      end
      d[0] = lerp(d[0], d[1], w[0]);
      d[2] = lerp(d[2], d[3], w[0]);
      d[4] = lerp(d[4], d[5], w[0]);
      d[6] = lerp(d[6], d[7], w[0]);
      d[0] = lerp(d[0], d[2], w[1]);
      d[4] = lerp(d[4], d[6], w[1]);
      r = lerp(d[0], d[4], w[2]);
      v = round_shift((r + one) * 65536, Frac + 1);
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      res.noise = v[15:0];
      res.oor = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [15:0] rand_grad();
      case ($urandom_range(0, 7))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [15:0] rand_frac();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_store(int x, int y, int z, logic [15:0] gx, logic [15:0] gy,
                             logic [15:0] gz);
      noise_req_type it;
      it = '{op: gn3_pkg::OpStore, cx: 4'(x), cy: 4'(y), cz: 4'(z), gx: gx, gy: gy, gz: gz,
             px: 20'($urandom), py: 20'($urandom), pz: 20'($urandom), drain_first: 0};
      pending_items.push_back(it);
      written[(x * Grid + y) * Grid + z] = 1'b1;
      items_made++;
   endtask

   // loads any unwritten corner of the cell, then queues the evaluation
   task automatic push_eval(logic [19:0] px, logic [19:0] py, logic [19:0] pz,
                            bit drain = 0);
      noise_req_type it;
      int bx, by, bz;
      bx = int'(px >> Frac); by = int'(py >> Frac); bz = int'(pz >> Frac);
      if (bx < Grid - 1 && by < Grid - 1 && bz < Grid - 1)
         for (int i = 0; i < 8; i++)
            if (!written[((bx + (i & 1)) * Grid + by + ((i >> 1) & 1)) * Grid
                         + bz + ((i >> 2) & 1)])
               push_store(bx + (i & 1), by + ((i >> 1) & 1), bz + ((i >> 2) & 1),
                          rand_grad(), rand_grad(), rand_grad());
      it = '{op: gn3_pkg::OpEval, cx: 4'($urandom), cy: 4'($urandom), cz: 4'($urandom),
             gx: 16'($urandom), gy: 16'($urandom), gz: 16'($urandom),
             px: px, py: py, pz: pz, drain_first: drain};
      pending_items.push_back(it);
      items_made++;
   endtask

   function automatic logic [19:0] rand_pos(bit allow_oor);
      int b;
      b = allow_oor ? $urandom_range(0, 15) : $urandom_range(0, Grid - 2);
      return {4'(b), rand_frac()};
   endfunction

   // stimulus
   initial begin
      int x, y, z;
      push_store(0, 0, 0, 16'sd16384, -16'sd16384, 16'sd16384);
      push_store(1, 0, 0, 16'h7fff, 16'h8000, 16'h0000);
      push_store(15, 15, 15, 16'hffff, 16'h0001, -16'sd16384);
      push_eval(20'h00000, 20'h00000, 20'h00000);
      push_eval(20'h0ffff, 20'h0ffff, 20'h0ffff);
      push_eval(20'h08000, 20'h08000, 20'h08000);
      push_eval(20'heffff, 20'heffff, 20'heffff);
      push_eval(20'hf0000, 20'h00000, 20'h00000);
      push_eval(20'h00000, 20'hf0000, 20'h00000);
      push_eval(20'h00000, 20'h00000, 20'hfffff);
      push_eval(20'hfffff, 20'hfffff, 20'hfffff);
      push_eval(20'he0000, 20'h00001, 20'h0fffe);
      while (items_made < TargetItems) begin
         case ($urandom_range(0, 9))
            0: push_eval(rand_pos(1), rand_pos(1), rand_pos(1));
            1: begin
               x = $urandom_range(0, 15); y = $urandom_range(0, 15);
               z = $urandom_range(0, 15);
               push_store(x, y, z, rand_grad(), rand_grad(), rand_grad());
            end
            2: begin
               // stay in a small region so cells get reused
               x = $urandom_range(0, 3);
               push_eval({4'(x), rand_frac()}, {4'(x), rand_frac()}, rand_pos(0));
            end
            default: push_eval(rand_pos(0), rand_pos(0), rand_pos(0),
                               $urandom_range(0, 99) == 0);
         endcase
      end
      pending_items[pending_items.size() / 2].drain_first = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_noise.size() == 0);
      repeat (30) @(posedge clock);
      if (errors == 0 && expected_noise.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      automatic noise_req_type it;
      automatic noise_rsp_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            it = '{op: req_operation, cx: req_cell_x, cy: req_cell_y, cz: req_cell_z,
                   gx: req_grad_x, gy: req_grad_y, gz: req_grad_z,
                   px: req_pos_x, py: req_pos_y, pz: req_pos_z, drain_first: 0};
            if (predict_noise(it, res))
               expected_noise.push_back(res);
            items_sent++;
            if (!quiet && $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 9);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain_first && expected_noise.size() > 0)) begin
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_operation <= it.op;
               req_cell_x <= it.cx; req_cell_y <= it.cy; req_cell_z <= it.cz;
               req_grad_x <= it.gx; req_grad_y <= it.gy; req_grad_z <= it.gz;
               req_pos_x <= it.px; req_pos_y <= it.py; req_pos_z <= it.pz;
               if (pending_items.size() < QuietTail)
                  quiet = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with one long hold-off early in the run
   int ready_gap = 0;
   int hold_cycles = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && items_sent >= 200) begin
         rsp_ready <= 1'b0;
         hold_cycles++;
         if (hold_cycles >= LongHold)
            hold_done = 1'b1;
      end else if (ready_gap > 0) begin
         ready_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 4) == 0)
            ready_gap = $urandom_range(1, 9);
      end
   end

   // monitor
   always @(posedge clock) begin
      automatic noise_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_noise.size() == 0) begin
            $display("%0t: unexpected result noise=%h oor=%b", $time,
                     rsp_noise_value, rsp_out_of_range);
            errors++;
         end else begin
            want = expected_noise.pop_front();
            if (rsp_noise_value !== want.noise) begin
               $display("%0t: noise_value expected %h actual %h", $time,
                        want.noise, rsp_noise_value);
               errors++;
            end
            if (rsp_out_of_range !== want.oor) begin
               $display("%0t: out_of_range expected %b actual %b", $time,
                        want.oor, rsp_out_of_range);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
